// File: rtl/sprite_dirty_rect_scheduler_top_assert.svh
// Assertion macros shared by the scheduler modules.
`ifndef SPRITE_DIRTY_RECT_SCHEDULER_TOP_ASSERT_SVH
`define SPRITE_DIRTY_RECT_SCHEDULER_TOP_ASSERT_SVH
// Check cons in the same cycle as ante.
`define SDRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check cons in the cycle after ante.
`define SDRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/sdrs_pkg.sv
`default_nettype none
package sdrs_pkg;

  localparam int ENT_W    = 4;
  localparam int CNT_W    = 6;
  localparam int MAX_CMDS = 48;

  localparam logic [3:0] OP_MAKE    = 4'd0;
  localparam logic [3:0] OP_DESTROY = 4'd1;
  localparam logic [3:0] OP_MOVE    = 4'd2;
  localparam logic [3:0] OP_RESIZE  = 4'd3;
  localparam logic [3:0] OP_HIDE    = 4'd4;
  localparam logic [3:0] OP_SHOW    = 4'd5;
  localparam logic [3:0] OP_SETCOL  = 4'd6;
  localparam logic [3:0] OP_RELCOL  = 4'd7;
  localparam logic [3:0] OP_FRAME   = 4'd8;

  localparam logic [2:0] KIND_DONE    = 3'd0;
  localparam logic [2:0] KIND_FILL    = 3'd1;
  localparam logic [2:0] KIND_RESTORE = 3'd2;
  localparam logic [2:0] KIND_CAPTURE = 3'd3;
  localparam logic [2:0] KIND_DRAW    = 3'd4;
  localparam logic [2:0] KIND_MADE    = 3'd5;

  localparam logic [1:0] ST_CLEAN      = 2'd0;
  localparam logic [1:0] ST_DIRTY_SP   = 2'd1;
  localparam logic [1:0] ST_DIRTY_BOTH = 2'd2;

  typedef logic signed [17:0] edge_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_MAKE,
    ACT_MARK,
    ACT_EDIT,
    ACT_LOAD_A,
    ACT_LOAD_B,
    ACT_PAIR_T,
    ACT_RLOAD,
    ACT_RSTEP,
    ACT_CAPTURE,
    ACT_DRAW,
    ACT_CLEAR,
    ACT_DONE
  } act_t;

  typedef struct packed {
    act_t             act;
    logic [ENT_W-1:0] idx;
    logic [ENT_W-1:0] jdx;
    logic [1:0]       k;
  } cmd_t;

  typedef struct packed {
    logic             stall;
    logic             rst_done;
    logic [3:0]       op;
    logic             ok;
    logic [ENT_W-1:0] id;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/sdrs_datapath.sv
`default_nettype none
`include "sprite_dirty_rect_scheduler_top_assert.svh"
module sdrs_datapath #(
  parameter int NUM_SPRITES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  sdrs_pkg::cmd_t      cmd,
  output sdrs_pkg::sts_t      sts,
  input  logic [3:0]          in_op,
  input  logic [2:0]          in_id,
  input  logic signed [15:0]  in_pos_x,
  input  logic signed [15:0]  in_pos_y,
  input  logic [9:0]          in_size_w,
  input  logic [9:0]          in_size_h,
  input  logic [15:0]         in_fill_color,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_kind,
  output logic [3:0]          out_entry,
  output logic signed [15:0]  out_rect_x,
  output logic signed [15:0]  out_rect_y,
  output logic [10:0]         out_rect_w,
  output logic [10:0]         out_rect_h,
  output logic [15:0]         out_color,
  output logic                out_last
);
  import sdrs_pkg::*;

  localparam int IW = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;

  logic              ent_active   [NUM_SPRITES];
  logic              ent_visible  [NUM_SPRITES];
  logic [1:0]        ent_status   [NUM_SPRITES];
  logic              ent_fixed_bg [NUM_SPRITES];
  logic [15:0]       ent_bg_color [NUM_SPRITES];
  logic signed [15:0] spr_x [NUM_SPRITES];
  logic signed [15:0] spr_y [NUM_SPRITES];
  logic [9:0]        spr_w [NUM_SPRITES];
  logic [9:0]        spr_h [NUM_SPRITES];
  logic signed [15:0] sav_x [NUM_SPRITES];
  logic signed [15:0] sav_y [NUM_SPRITES];
  logic [9:0]        sav_w [NUM_SPRITES];
  logic [9:0]        sav_h [NUM_SPRITES];
  logic              sav_valid  [NUM_SPRITES];
  logic              has_pixels [NUM_SPRITES];

  logic [3:0]         op_r;
  logic [2:0]         id_r;
  logic signed [15:0] px_r, py_r;
  logic [9:0]         sw_r, sh_r;
  logic [15:0]        col_r;
  logic [CNT_W-1:0]   n_cnt;

  edge_t a_x, a_y, a_xr, a_yb, b_x, b_y, b_xr, b_yb;
  logic  a_ok, a_fixed, b_ok, b_fixed;

  logic        r_en, r_fixed, r_savv, r_full;
  logic [15:0] r_color;
  logic [9:0]  r_sw, r_sh;
  edge_t r_bx, r_by, r_bxr, r_byb, r_sx, r_sy, r_sxr, r_syb;

  logic [IW-1:0]    ix, jx;
  logic [ENT_W-1:0] free_idx;
  logic             free_found;
  logic             ok;
  edge_t rd_x, rd_y, rd_xr, rd_yb;
  logic  touch, pair_hit;
  edge_t lln, rln, bx0, by0, bx1, by1, bw, bh;
  logic  want_box;

  logic             em_req, em_force, em_last, rst_done;
  logic [2:0]       em_kind;
  logic [ENT_W-1:0] em_ent;
  logic [15:0]      em_x, em_y, em_col;
  logic [10:0]      em_w, em_h;
  logic             drop, stall, fire, wr;

  assign ix = cmd.idx[IW-1:0];
  assign jx = cmd.jdx[IW-1:0];
  assign ok = int'(id_r) < NUM_SPRITES;

  always_comb begin
    free_idx   = ENT_W'(NUM_SPRITES);
    free_found = 1'b0;
    for (int e = NUM_SPRITES - 1; e >= 0; e--) begin
      if (!ent_active[e]) begin
        free_idx   = ENT_W'(e);
        free_found = 1'b1;
      end
    end
  end

  // bounding box of sprite and saved rectangles at the read index
  always_comb begin
    edge_t sxe, sye, sre, sbe, bxe, bye, bre, bbe;
    sxe   = edge_t'(spr_x[ix]);
    sye   = edge_t'(spr_y[ix]);
    sre   = edge_t'(spr_x[ix]) + edge_t'(spr_w[ix]);
    sbe   = edge_t'(spr_y[ix]) + edge_t'(spr_h[ix]);
    bxe   = edge_t'(sav_x[ix]);
    bye   = edge_t'(sav_y[ix]);
    bre   = edge_t'(sav_x[ix]) + edge_t'(sav_w[ix]);
    bbe   = edge_t'(sav_y[ix]) + edge_t'(sav_h[ix]);
    rd_x  = (sxe < bxe) ? sxe : bxe;
    rd_y  = (sye < bye) ? sye : bye;
    rd_xr = (sre > bre) ? sre : bre;
    rd_yb = (sbe > bbe) ? sbe : bbe;
  end

  assign pair_hit = a_ok && b_ok && !(a_fixed && b_fixed) &&
                    !(b_x >= a_xr || b_xr <= a_x || b_y >= a_yb || b_yb <= a_y);

  assign touch = !(r_sx > r_bxr || r_sxr < r_bx || r_sy > r_byb || r_syb < r_by);
  assign lln   = (r_bx < r_sx) ? r_sx : r_bx;
  assign rln   = (r_bxr > r_sxr) ? r_sxr : r_bxr;

  always_comb begin
    want_box = 1'b0;
    bx0 = r_bx; by0 = r_by; bx1 = r_bxr; by1 = r_byb;
    case (cmd.k)
      2'd0: begin
        want_box = r_bx < r_sx;
        bx1 = r_sx;
      end
      2'd1: begin
        want_box = r_bxr > r_sxr;
        bx0 = r_sxr;
      end
      2'd2: begin
        want_box = r_by < r_sy;
        bx0 = lln; bx1 = rln; by1 = r_sy;
      end
      2'd3: begin
        want_box = r_byb > r_syb;
        bx0 = lln; bx1 = rln; by0 = r_syb;
      end
      default: ;
    endcase
    if (r_full || !touch) begin
      want_box = 1'b1;
      bx0 = r_bx; by0 = r_by; bx1 = r_bxr; by1 = r_byb;
    end
  end

  assign bw = bx1 - bx0;
  assign bh = by1 - by0;

  always_comb begin
    em_req   = 1'b0;
    em_force = 1'b0;
    em_last  = 1'b0;
    em_kind  = KIND_DONE;
    em_ent   = cmd.idx;
    em_x     = '0;
    em_y     = '0;
    em_w     = '0;
    em_h     = '0;
    em_col   = '0;
    rst_done = 1'b0;
    case (cmd.act)
      ACT_MAKE: begin
        em_req   = 1'b1;
        em_force = 1'b1;
        em_last  = 1'b1;
        em_kind  = KIND_MADE;
        em_ent   = free_idx;
      end
      ACT_DONE: begin
        em_req   = 1'b1;
        em_force = 1'b1;
        em_last  = 1'b1;
        em_ent   = '0;
      end
      ACT_RSTEP: begin
        if (!r_en) begin
          rst_done = 1'b1;
        end else if (!r_fixed) begin
          rst_done = 1'b1;
          em_req   = r_savv;
          em_kind  = KIND_RESTORE;
          em_x     = r_bx[15:0];
          em_y     = r_by[15:0];
          em_w     = {1'b0, r_sw};
          em_h     = {1'b0, r_sh};
        end else begin
          rst_done = r_full || !touch || (cmd.k == 2'd3);
          em_req   = want_box && (bw > 0) && (bh > 0);
          em_kind  = KIND_FILL;
          em_x     = bx0[15:0];
          em_y     = by0[15:0];
          em_w     = bw[10:0];
          em_h     = bh[10:0];
          em_col   = r_color;
        end
      end
      ACT_CAPTURE: begin
        em_req  = ent_active[ix] && ent_visible[ix] && !ent_fixed_bg[ix] &&
                  (ent_status[ix] == ST_DIRTY_BOTH || !sav_valid[ix]);
        em_kind = KIND_CAPTURE;
        em_x    = spr_x[ix];
        em_y    = spr_y[ix];
        em_w    = {1'b0, spr_w[ix]};
        em_h    = {1'b0, spr_h[ix]};
      end
      ACT_DRAW: begin
        em_req  = ent_active[ix] && ent_visible[ix] && has_pixels[ix] &&
                  ent_status[ix] != ST_CLEAN;
        em_kind = KIND_DRAW;
        em_x    = spr_x[ix];
        em_y    = spr_y[ix];
        em_w    = {1'b0, spr_w[ix]};
        em_h    = {1'b0, spr_h[ix]};
      end
      default: ;
    endcase
  end

  assign drop  = !em_force && (n_cnt >= CNT_W'(MAX_CMDS));
  assign stall = em_req && !drop && out_valid && !out_ready;
  assign fire  = !stall;
  assign wr    = em_req && !drop && fire;

  assign sts.stall    = stall;
  assign sts.rst_done = rst_done;
  assign sts.op       = op_r;
  assign sts.ok       = ok;
  assign sts.id       = ENT_W'(id_r);

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_LOAD) begin
      op_r  <= in_op;
      id_r  <= in_id;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      sw_r  <= in_size_w;
      sh_r  <= in_size_h;
      col_r <= in_fill_color;
    end
    if (cmd.act == ACT_LOAD_A) begin
      a_x     <= rd_x;
      a_y     <= rd_y;
      a_xr    <= rd_xr;
      a_yb    <= rd_yb;
      a_ok    <= ent_active[ix] && spr_w[ix] != '0;
      a_fixed <= ent_fixed_bg[ix];
    end
    if (cmd.act == ACT_LOAD_B) begin
      b_x     <= rd_x;
      b_y     <= rd_y;
      b_xr    <= rd_xr;
      b_yb    <= rd_yb;
      b_ok    <= ent_active[ix] && spr_w[ix] != '0;
      b_fixed <= ent_fixed_bg[ix];
    end
    if (cmd.act == ACT_RLOAD) begin
      r_en    <= ent_active[ix] && ent_status[ix] == ST_DIRTY_BOTH;
      r_fixed <= ent_fixed_bg[ix];
      r_savv  <= sav_valid[ix];
      r_full  <= !ent_visible[ix] || sav_w[ix] == '0 || spr_w[ix] == '0;
      r_color <= ent_bg_color[ix];
      r_sw    <= sav_w[ix];
      r_sh    <= sav_h[ix];
      r_bx    <= edge_t'(sav_x[ix]);
      r_by    <= edge_t'(sav_y[ix]);
      r_bxr   <= edge_t'(sav_x[ix]) + edge_t'(sav_w[ix]);
      r_byb   <= edge_t'(sav_y[ix]) + edge_t'(sav_h[ix]);
      r_sx    <= edge_t'(spr_x[ix]);
      r_sy    <= edge_t'(spr_y[ix]);
      r_sxr   <= edge_t'(spr_x[ix]) + edge_t'(spr_w[ix]);
      r_syb   <= edge_t'(spr_y[ix]) + edge_t'(spr_h[ix]);
    end
    if (wr) begin
      out_kind   <= em_kind;
      out_entry  <= em_ent;
      out_rect_x <= em_x;
      out_rect_y <= em_y;
      out_rect_w <= em_w;
      out_rect_h <= em_h;
      out_color  <= em_col;
      out_last   <= em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      n_cnt     <= '0;
    end else begin
      if (wr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.act == ACT_LOAD) begin
        n_cnt <= '0;
      end else if (wr && !em_force) begin
        n_cnt <= n_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < NUM_SPRITES; e++) begin
        ent_active[e]   <= 1'b0;
        ent_visible[e]  <= 1'b0;
        ent_status[e]   <= ST_CLEAN;
        ent_fixed_bg[e] <= 1'b0;
        ent_bg_color[e] <= '0;
        spr_x[e]        <= '0;
        spr_y[e]        <= '0;
        spr_w[e]        <= '0;
        spr_h[e]        <= '0;
        sav_x[e]        <= '0;
        sav_y[e]        <= '0;
        sav_w[e]        <= '0;
        sav_h[e]        <= '0;
        sav_valid[e]    <= 1'b0;
        has_pixels[e]   <= 1'b0;
      end
    end else if (fire) begin
      case (cmd.act)
        ACT_MAKE: begin
          if (free_found) begin
            ent_active[free_idx[IW-1:0]]  <= 1'b1;
            ent_visible[free_idx[IW-1:0]] <= 1'b1;
            ent_status[free_idx[IW-1:0]]  <= ST_DIRTY_BOTH;
          end
        end
        ACT_MARK: begin
          for (int e = 0; e < NUM_SPRITES; e++) begin
            if (ent_active[e] && ent_visible[e] &&
                (sav_x[e] != spr_x[e] || sav_y[e] != spr_y[e] ||
                 sav_w[e] != spr_w[e] || sav_h[e] != spr_h[e])) begin
              ent_status[e] <= ST_DIRTY_BOTH;
            end
          end
        end
        ACT_EDIT: begin
          case (op_r)
            OP_DESTROY, OP_HIDE: begin
              if (ent_visible[ix]) begin
                ent_status[ix]  <= ST_DIRTY_BOTH;
                ent_visible[ix] <= 1'b0;
              end
            end
            OP_SHOW: begin
              if (!ent_visible[ix]) begin
                ent_status[ix]  <= ST_DIRTY_BOTH;
                ent_visible[ix] <= 1'b1;
              end
            end
            OP_MOVE: begin
              spr_x[ix] <= px_r;
              spr_y[ix] <= py_r;
            end
            OP_RESIZE: begin
              if (sw_r != '0 && sh_r != '0) begin
                spr_w[ix]      <= sw_r;
                spr_h[ix]      <= sh_r;
                has_pixels[ix] <= 1'b1;
                if (ent_status[ix] != ST_DIRTY_BOTH) begin
                  ent_status[ix] <= ST_DIRTY_SP;
                end
              end
            end
            OP_SETCOL: begin
              ent_bg_color[ix] <= col_r;
              ent_fixed_bg[ix] <= 1'b1;
            end
            OP_RELCOL: begin
              ent_bg_color[ix] <= '0;
              ent_fixed_bg[ix] <= 1'b0;
            end
            default: ;
          endcase
        end
        ACT_PAIR_T: begin
          if (pair_hit) begin
            ent_status[ix] <= ST_DIRTY_BOTH;
            ent_status[jx] <= ST_DIRTY_BOTH;
          end
        end
        ACT_CAPTURE: begin
          if (ent_active[ix] && ent_visible[ix] &&
              (ent_status[ix] == ST_DIRTY_BOTH || !sav_valid[ix])) begin
            if (!ent_fixed_bg[ix]) begin
              sav_valid[ix] <= 1'b1;
            end
            sav_x[ix]      <= spr_x[ix];
            sav_y[ix]      <= spr_y[ix];
            sav_w[ix]      <= spr_w[ix];
            sav_h[ix]      <= spr_h[ix];
            ent_status[ix] <= ST_DIRTY_SP;
          end
        end
        ACT_DRAW: begin
          if (ent_active[ix] && ent_visible[ix] && ent_status[ix] != ST_CLEAN) begin
            ent_status[ix] <= ST_CLEAN;
          end
        end
        ACT_CLEAR: begin
          ent_active[ix]   <= 1'b0;
          ent_visible[ix]  <= 1'b0;
          ent_status[ix]   <= ST_CLEAN;
          ent_fixed_bg[ix] <= 1'b0;
          ent_bg_color[ix] <= '0;
          spr_x[ix]        <= '0;
          spr_y[ix]        <= '0;
          spr_w[ix]        <= '0;
          spr_h[ix]        <= '0;
          sav_x[ix]        <= '0;
          sav_y[ix]        <= '0;
          sav_w[ix]        <= '0;
          sav_h[ix]        <= '0;
          sav_valid[ix]    <= 1'b0;
          has_pixels[ix]   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  `SDRS_ASSERT_NOW(a_cnt_max, 1'b1, n_cnt <= CNT_W'(MAX_CMDS), "command count overran")
  `SDRS_ASSERT_NEXT(a_cnt_clear, cmd.act == ACT_LOAD, n_cnt == '0, "count not cleared")

endmodule
`default_nettype wire

// File: rtl/sdrs_ctrl.sv
`default_nettype none
`include "sprite_dirty_rect_scheduler_top_assert.svh"
module sdrs_ctrl #(
  parameter int NUM_SPRITES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output sdrs_pkg::cmd_t cmd,
  input  sdrs_pkg::sts_t sts
);
  import sdrs_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_PAIR_A = 11'b00000000100,
    S_PAIR_B = 11'b00000001000,
    S_PAIR_T = 11'b00000010000,
    S_RLOAD  = 11'b00000100000,
    S_RSTEP  = 11'b00001000000,
    S_CAP    = 11'b00010000000,
    S_DRAW   = 11'b00100000000,
    S_CLEAR  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  localparam logic [ENT_W-1:0] LAST = ENT_W'(NUM_SPRITES - 1);

  state_t           state, state_next;
  logic [ENT_W-1:0] i, i_next, j, j_next;
  logic [1:0]       k, k_next;
  logic             single, single_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    i_next      = i;
    j_next      = j;
    k_next      = k;
    single_next = single;
    cmd.act     = ACT_NONE;
    cmd.idx     = i;
    cmd.jdx     = j;
    cmd.k       = k;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.act    = ACT_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.idx = sts.id;
        if (sts.op == OP_MAKE) begin
          cmd.act = ACT_MAKE;
          if (!sts.stall) begin
            state_next = S_IDLE;
          end
        end else if (sts.op == OP_FRAME) begin
          cmd.act    = ACT_MARK;
          i_next     = '0;
          state_next = S_PAIR_A;
        end else if (sts.ok && sts.op >= OP_DESTROY && sts.op <= OP_RELCOL) begin
          cmd.act = ACT_EDIT;
          if (sts.op == OP_DESTROY) begin
            i_next      = sts.id;
            k_next      = '0;
            single_next = 1'b1;
            state_next  = S_RLOAD;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_PAIR_A: begin
        cmd.act    = ACT_LOAD_A;
        j_next     = i + 1'b1;
        state_next = S_PAIR_B;
      end
      S_PAIR_B: begin
        cmd.act    = ACT_LOAD_B;
        cmd.idx    = j;
        state_next = S_PAIR_T;
      end
      S_PAIR_T: begin
        cmd.act = ACT_PAIR_T;
        if (j == LAST) begin
          if (i == LAST - 1'b1) begin
            i_next      = '0;
            k_next      = '0;
            single_next = 1'b0;
            state_next  = S_RLOAD;
          end else begin
            i_next     = i + 1'b1;
            state_next = S_PAIR_A;
          end
        end else begin
          j_next     = j + 1'b1;
          state_next = S_PAIR_B;
        end
      end
      S_RLOAD: begin
        cmd.act    = ACT_RLOAD;
        k_next     = '0;
        state_next = S_RSTEP;
      end
      S_RSTEP: begin
        cmd.act = ACT_RSTEP;
        if (!sts.stall) begin
          if (sts.rst_done) begin
            k_next = '0;
            if (single) begin
              state_next = S_CLEAR;
            end else if (i == LAST) begin
              i_next     = '0;
              state_next = S_CAP;
            end else begin
              i_next     = i + 1'b1;
              state_next = S_RLOAD;
            end
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      S_CAP: begin
        cmd.act = ACT_CAPTURE;
        if (!sts.stall) begin
          if (i == LAST) begin
            i_next     = '0;
            state_next = S_DRAW;
          end else begin
            i_next = i + 1'b1;
          end
        end
      end
      S_DRAW: begin
        cmd.act = ACT_DRAW;
        if (!sts.stall) begin
          if (i == LAST) begin
            state_next = S_DONE;
          end else begin
            i_next = i + 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd.act    = ACT_CLEAR;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.act = ACT_DONE;
        if (!sts.stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      i      <= '0;
      j      <= '0;
      k      <= '0;
      single <= 1'b0;
    end else begin
      state  <= state_next;
      i      <= i_next;
      j      <= j_next;
      k      <= k_next;
      single <= single_next;
    end
  end

  `SDRS_ASSERT_NEXT(a_accept, in_valid && in_ready, state == S_DECODE, "accept not decoded")
  `SDRS_ASSERT_NOW(a_pair_order, state == S_PAIR_T, j > i && j <= LAST, "bad pair index")
  `SDRS_ASSERT_NOW(a_box_step, state != S_RSTEP, k == '0, "box step left nonzero")

endmodule
`default_nettype wire

// File: rtl/sprite_dirty_rect_scheduler_top.sv
// Sprite dirty-rectangle scheduler. Each input transaction is one table operation
// (make, destroy, move, resize, hide, show, set or release background colour) or a
// frame operation; its output transactions are blitter commands ending with one
// transaction flagged by tlast (a done, or the made entry for make). The controller
// walks entries and sprite pairs one step per cycle while not stalled, through a
// single table read port; an emitted command stalls the walk only while the output
// register is still held by the sink. At most 48 commands per operation are sent
// ahead of the closing tlast transaction.
`default_nettype none
module sprite_dirty_rect_scheduler_top #(
  parameter int NUM_SPRITES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // sprite_id, pos_x, pos_y, size_w, size_h, fill_color
  input  logic [3:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // entry, rect_x, rect_y, rect_w, rect_h, out_color
  output logic [2:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);
  import sdrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [3:0]         o_entry;
  logic signed [15:0] o_x, o_y;
  logic [10:0]        o_w, o_h;
  logic [15:0]        o_col;

  sdrs_ctrl #(.NUM_SPRITES(NUM_SPRITES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sdrs_datapath #(.NUM_SPRITES(NUM_SPRITES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (s_axis_tuser),
    .in_id         (s_axis_tdata[2:0]),
    .in_pos_x      (s_axis_tdata[18:3]),
    .in_pos_y      (s_axis_tdata[34:19]),
    .in_size_w     (s_axis_tdata[44:35]),
    .in_size_h     (s_axis_tdata[54:45]),
    .in_fill_color (s_axis_tdata[70:55]),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_kind      (m_axis_tuser),
    .out_entry     (o_entry),
    .out_rect_x    (o_x),
    .out_rect_y    (o_y),
    .out_rect_w    (o_w),
    .out_rect_h    (o_h),
    .out_color     (o_col),
    .out_last      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, o_col, o_h, o_w, o_y, o_x, o_entry};

endmodule
`default_nettype wire

// File: dv/sprite_dirty_rect_scheduler_top_test.sv
`default_nettype none
module sprite_dirty_rect_scheduler_top_test;
  import sdrs_pkg::*;

  localparam int NSPR = 8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  entry;
    logic [15:0] x;
    logic [15:0] y;
    logic [10:0] w;
    logic [10:0] h;
    logic [15:0] color;
    logic        last;
  } blit_cmd_t;

  typedef struct {
    logic [3:0]  op;
    logic [2:0]  id;
    logic [15:0] px;
    logic [15:0] py;
    logic [9:0]  sw;
    logic [9:0]  sh;
    logic [15:0] col;
  } table_op_t;

  typedef struct {
    table_op_t   item;
    bit          typed;
    logic [2:0]  exp_kind;
    logic [3:0]  exp_entry;
  } directed_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  sprite_dirty_rect_scheduler_top #(.NUM_SPRITES(NSPR)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #10 clk = ~clk;

  // sprite table shadow
  bit         act[NSPR], vis[NSPR], fixbg[NSPR], savv[NSPR], pix[NSPR];
  logic [1:0] st[NSPR];
  logic [15:0] bgc[NSPR];
  int         sx[NSPR], sy[NSPR], sw[NSPR], sh[NSPR];
  int         vx[NSPR], vy[NSPR], vw[NSPR], vh[NSPR];

  blit_cmd_t  pending_cmds[$];
  int         ncmd;
  int         errs = 0;
  int         nresults = 0;
  int         nframes = 0;
  int         naccepted = 0;
  bit         calm = 0;

  function automatic void clear_entry(int i);
    act[i] = 0; vis[i] = 0; fixbg[i] = 0; savv[i] = 0; pix[i] = 0;
    st[i] = ST_CLEAN; bgc[i] = '0;
    sx[i] = 0; sy[i] = 0; sw[i] = 0; sh[i] = 0;
    vx[i] = 0; vy[i] = 0; vw[i] = 0; vh[i] = 0;
  endfunction

  function automatic void push_cmd(logic [2:0] kind, int entry, int x, int y, int w, int h,
                                   logic [15:0] color);
    blit_cmd_t c;
    if (ncmd >= MAX_CMDS) return;
    c.kind = kind; c.entry = entry[3:0]; c.x = x[15:0]; c.y = y[15:0];
    c.w = w[10:0]; c.h = h[10:0]; c.color = color; c.last = 0;
    pending_cmds.push_back(c);
    ncmd++;
  endfunction

  function automatic void fill_box(int i, int x, int y, int xr, int yb);
    if (xr - x > 0 && yb - y > 0) push_cmd(KIND_FILL, i, x, y, xr - x, yb - y, bgc[i]);
  endfunction

  function automatic bit overlap(int ax, int ay, int axr, int ayb,
                                 int bx, int by, int bxr, int byb);
    return !(bx > axr || bxr < ax || by > ayb || byb < ay);
  endfunction

  function automatic void restore_bg(int i);
    int bx, by, bxr, byb, px, py, pxr, pyb, lln, rln;
    if (!act[i] || st[i] != ST_DIRTY_BOTH) return;
    if (!fixbg[i]) begin
      if (savv[i]) push_cmd(KIND_RESTORE, i, vx[i], vy[i], vw[i], vh[i], '0);
      return;
    end
    bx = vx[i]; by = vy[i]; bxr = bx + vw[i]; byb = by + vh[i];
    px = sx[i]; py = sy[i]; pxr = px + sw[i]; pyb = py + sh[i];
    if (!vis[i] || vw[i] <= 0 || sw[i] <= 0 || !overlap(bx, by, bxr, byb, px, py, pxr, pyb)) begin
      fill_box(i, bx, by, bxr, byb);
      return;
    end
    lln = bx;
    rln = bxr;
    if (bx < px) begin
      fill_box(i, bx, by, px, byb);
      lln = px;
    end
    if (bxr > pxr) begin
      fill_box(i, pxr, by, bxr, byb);
      rln = pxr;
    end
    if (by < py) fill_box(i, lln, by, rln, py);
    if (byb > pyb) fill_box(i, lln, pyb, rln, byb);
  endfunction

  function automatic void bound_box(int i, output int x, output int y, output int xr,
                                    output int yb);
    x = sx[i] < vx[i] ? sx[i] : vx[i];
    y = sy[i] < vy[i] ? sy[i] : vy[i];
    xr = sx[i] + sw[i] > vx[i] + vw[i] ? sx[i] + sw[i] : vx[i] + vw[i];
    yb = sy[i] + sh[i] > vy[i] + vh[i] ? sy[i] + sh[i] : vy[i] + vh[i];
  endfunction

  function automatic bit sprites_collide(int a, int b);
    int ax, ay, axr, ayb, bx, by, bxr, byb;
    if (!act[a] || !act[b] || sw[a] <= 0 || sw[b] <= 0) return 0;
    bound_box(a, ax, ay, axr, ayb);
    bound_box(b, bx, by, bxr, byb);
    return overlap(ax, ay, axr - 1, ayb - 1, bx, by, bxr - 1, byb - 1);
  endfunction

  function automatic void compose_frame();
    for (int i = 0; i < NSPR; i++)
      if (act[i] && vis[i] && (vx[i] != sx[i] || vy[i] != sy[i] || vw[i] != sw[i] ||
                               vh[i] != sh[i]))
        st[i] = ST_DIRTY_BOTH;
    for (int i = 0; i < NSPR; i++) begin
      if (!act[i]) continue;
      for (int j = i + 1; j < NSPR; j++) begin
        if (!act[j]) continue;
        if ((st[i] != ST_DIRTY_BOTH || st[j] != ST_DIRTY_BOTH) && (!fixbg[i] || !fixbg[j]) &&
            sprites_collide(i, j)) begin
          st[i] = ST_DIRTY_BOTH;
          st[j] = ST_DIRTY_BOTH;
        end
      end
    end
    for (int i = 0; i < NSPR; i++) if (act[i]) restore_bg(i);
    for (int i = 0; i < NSPR; i++)
      if (act[i] && vis[i] && (st[i] == ST_DIRTY_BOTH || !savv[i])) begin
        if (!fixbg[i]) begin
          savv[i] = 1;
          push_cmd(KIND_CAPTURE, i, sx[i], sy[i], sw[i], sh[i], '0);
        end
        vx[i] = sx[i]; vy[i] = sy[i]; vw[i] = sw[i]; vh[i] = sh[i];
        st[i] = ST_DIRTY_SP;
      end
    for (int i = 0; i < NSPR; i++)
      if (act[i] && vis[i] && st[i] != ST_CLEAN) begin
        if (pix[i]) push_cmd(KIND_DRAW, i, sx[i], sy[i], sw[i], sh[i], '0);
        st[i] = ST_CLEAN;
      end
  endfunction

  function automatic void predict_commands(table_op_t t);
    blit_cmd_t fin;
    int i, id;
    id = t.id;
    ncmd = 0;
    fin = '{KIND_DONE, '0, '0, '0, '0, '0, '0, 1'b1};
    if (t.op == OP_MAKE) begin
      for (i = 0; i < NSPR; i++) if (!act[i]) break;
      if (i < NSPR) begin
        vis[i] = 1; act[i] = 1; st[i] = ST_DIRTY_BOTH;
      end
      fin.kind = KIND_MADE;
      fin.entry = i[3:0];
      pending_cmds.push_back(fin);
      return;
    end
    if (t.op == OP_FRAME) begin
      compose_frame();
      nframes++;
    end else if (id < NSPR) begin
      case (t.op)
        OP_DESTROY: begin
          if (vis[id]) begin
            st[id] = ST_DIRTY_BOTH; vis[id] = 0;
          end
          restore_bg(id);
          clear_entry(id);
        end
        OP_MOVE: begin
          sx[id] = $signed(t.px); sy[id] = $signed(t.py);
        end
        OP_RESIZE: if (t.sw != 0 && t.sh != 0) begin
          sw[id] = t.sw; sh[id] = t.sh; pix[id] = 1;
          if (st[id] != ST_DIRTY_BOTH) st[id] = ST_DIRTY_SP;
        end
        OP_HIDE: if (vis[id]) begin
          st[id] = ST_DIRTY_BOTH; vis[id] = 0;
        end
        OP_SHOW: if (!vis[id]) begin
          st[id] = ST_DIRTY_BOTH; vis[id] = 1;
        end
        OP_SETCOL: begin
          bgc[id] = t.col; fixbg[id] = 1;
        end
        OP_RELCOL: begin
          bgc[id] = '0; fixbg[id] = 0;
        end
        default: ;
      endcase
    end
    pending_cmds.push_back(fin);
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink stall
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tready && m_axis_tvalid && gap_len() > 0) begin
      stall_left <= gap_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare outgoing commands
  always @(posedge clk) begin
    blit_cmd_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.entry = m_axis_tdata[3:0];
      got.x = m_axis_tdata[19:4];
      got.y = m_axis_tdata[35:20];
      got.w = m_axis_tdata[46:36];
      got.h = m_axis_tdata[57:47];
      got.color = m_axis_tdata[73:58];
      got.last = m_axis_tlast;
      nresults++;
      if (pending_cmds.size() == 0) begin
        errs++;
        if (errs <= 10)
          $display("unexpected command kind=%0d entry=%0d x=%h y=%h w=%0d h=%0d c=%h last=%b",
                   got.kind, got.entry, got.x, got.y, got.w, got.h, got.color, got.last);
      end else begin
        want = pending_cmds.pop_front();
        if (got != want) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: exp kind=%0d entry=%0d x=%h y=%h w=%0d h=%0d c=%h last=%b, got kind=%0d entry=%0d x=%h y=%h w=%0d h=%0d c=%h last=%b",
                     want.kind, want.entry, want.x, want.y, want.w, want.h, want.color,
                     want.last, got.kind, got.entry, got.x, got.y, got.w, got.h,
                     got.color, got.last);
        end
      end
    end
  end

  task automatic send_op(table_op_t t, int pause);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= t.op;
    s_axis_tdata <= {1'b0, t.col, t.sh, t.sw, t.py, t.px, t.id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    naccepted++;
    if (pause > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  function automatic table_op_t random_op();
    table_op_t t;
    int r;
    r = $urandom_range(0, 99);
    t.id = $urandom_range(0, 7);
    t.col = $urandom;
    t.px = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 300) - 50) : 16'($urandom);
    t.py = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 300) - 50) : 16'($urandom);
    t.sw = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(1, 64)) :
           (($urandom_range(0, 1) == 0) ? 10'd0 : 10'($urandom));
    t.sh = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(1, 64)) :
           (($urandom_range(0, 1) == 0) ? 10'd0 : 10'($urandom));
    if (r < 12) t.op = OP_MAKE;
    else if (r < 18) t.op = OP_DESTROY;
    else if (r < 35) t.op = OP_MOVE;
    else if (r < 47) t.op = OP_RESIZE;
    else if (r < 53) t.op = OP_HIDE;
    else if (r < 59) t.op = OP_SHOW;
    else if (r < 65) t.op = OP_SETCOL;
    else if (r < 70) t.op = OP_RELCOL;
    else if (r < 95) t.op = OP_FRAME;
    else t.op = 4'($urandom_range(9, 15));
    return t;
  endfunction

  function automatic directed_row_t row(logic [3:0] op, logic [2:0] id, logic [15:0] px,
                                        logic [15:0] py, logic [9:0] w, logic [9:0] h,
                                        logic [15:0] col, bit typed = 0,
                                        logic [2:0] k = KIND_DONE, logic [3:0] e = 0);
    directed_row_t d;
    d.item = '{op, id, px, py, w, h, col};
    d.typed = typed; d.exp_kind = k; d.exp_entry = e;
    return d;
  endfunction

  directed_row_t plan[$];

  initial begin
    blit_cmd_t first;
    for (int i = 0; i < NSPR; i++) clear_entry(i);
    plan.push_back(row(OP_FRAME, 0, 0, 0, 0, 0, 0, 1, KIND_DONE, 0));
    for (int i = 0; i < NSPR; i++)
      plan.push_back(row(OP_MAKE, 0, 0, 0, 0, 0, 0, 1, KIND_MADE, 4'(i)));
    plan.push_back(row(OP_MAKE, 0, 0, 0, 0, 0, 0, 1, KIND_MADE, 4'd8));
    plan.push_back(row(OP_RESIZE, 0, 0, 0, 0, 10, 0));
    plan.push_back(row(OP_RESIZE, 0, 0, 0, 10'h3ff, 10'h3ff, 0));
    plan.push_back(row(OP_MOVE, 0, 16'h8000, 16'h8000, 0, 0, 0));
    plan.push_back(row(OP_MOVE, 1, 16'h7fff, 16'h7fff, 0, 0, 0));
    plan.push_back(row(OP_RESIZE, 1, 0, 0, 10'h3ff, 10'h3ff, 0));
    plan.push_back(row(OP_SETCOL, 1, 0, 0, 0, 0, 16'hffff));
    plan.push_back(row(OP_HIDE, 2, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_SHOW, 2, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_FRAME, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_MOVE, 1, 16'd100, 16'd100, 0, 0, 0));
    plan.push_back(row(OP_FRAME, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_RELCOL, 1, 0, 0, 0, 0, 0));
    plan.push_back(row(OP_DESTROY, 3, 0, 0, 0, 0, 0));
    plan.push_back(row(4'd15, 7, 16'hffff, 16'hffff, 10'h3ff, 10'h3ff, 16'hffff, 1, KIND_DONE, 0));
    plan.push_back(row(OP_FRAME, 0, 0, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      int base;
      base = pending_cmds.size();
      predict_commands(plan[r].item);
      if (plan[r].typed) begin
        first = pending_cmds[base];
        if (first.kind != plan[r].exp_kind || first.entry != plan[r].exp_entry) begin
          errs++;
          if (errs <= 10)
            $display("row %0d: predicted kind=%0d entry=%0d, table says kind=%0d entry=%0d",
                     r, first.kind, first.entry, plan[r].exp_kind, plan[r].exp_entry);
        end
      end
      send_op(plan[r].item, gap_len());
    end

    for (int n = 0; n < 480; n++) begin
      table_op_t t;
      if (n % 60 == 0) calm = ($urandom_range(0, 2) == 0);
      t = random_op();
      predict_commands(t);
      send_op(t, gap_len());
    end
    s_axis_tvalid <= 1'b0;
    calm = 1;

    for (int w = 0; w < 200000 && pending_cmds.size() != 0; w++) @(posedge clk);
    repeat (200) @(posedge clk);
    if (pending_cmds.size() != 0) errs++;
    $display("%0d operations sent (%0d frames), %0d blitter commands checked, %0d errors",
             naccepted, nframes, nresults, errs);
    if (errs == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #400000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
